>>> rtl/core/skeleton_forward_kinematics_top_assert.svh
// Assertion macros for the skeleton forward kinematics block.
`ifndef SKELETON_FORWARD_KINEMATICS_TOP_ASSERT_SVH
`define SKELETON_FORWARD_KINEMATICS_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SFK_ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define SFK_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

>>> rtl/core/sfk_pkg.sv
// Shared types and constants for the skeleton forward kinematics block.
package sfk_pkg;
	localparam int InW = 9 + 3 * 32 + 4 * 16 + 1;
	localparam int InBytes = (InW - 1) / 8 + 1;
	localparam int OutDW = 3 * 32 + 4 * 16 + 2 * 32;
	localparam int OutBytes = (OutDW - 1) / 8 + 1;
	localparam logic signed [31:0] PosMax = 32'sh7fffffff;
	localparam logic signed [31:0] PosMin = 32'sh80000000;

	typedef struct packed {
		logic               last;
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic signed [15:0] qy;
		logic signed [15:0] qx;
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
		logic signed [8:0]  parent;
	} joint_t;

	typedef struct packed {
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic signed [15:0] qy;
		logic signed [15:0] qx;
		logic signed [31:0] z;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} pose_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sh0000_7fffffff) return PosMax;
		if (v < -48'sh0000_80000000) return PosMin;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		if (v > 36'sh0_0000_7fff) return 16'sh7fff;
		if (v < -36'sh0_0000_8000) return 16'sh8000;
		return v[15:0];
	endfunction
endpackage

>>> rtl/core/sfk_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module sfk_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/sfk_front.sv
// Input stage: accepts joints and queues them for the kinematics engine.
module sfk_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sfk_pkg::joint_t in_joint,
	output logic            q_valid,
	input  logic            q_ready,
	output sfk_pkg::joint_t q_joint
);
	import sfk_pkg::*;

	joint_t slot_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_joint  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) slot_q[wr_q] <= in_joint;
	end
endmodule

>>> rtl/core/sfk_back.sv
// Kinematics engine: pose tables, sequenced rotation math and output register.
module sfk_back #(
	parameter int MaxJoints = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  sfk_pkg::joint_t q_joint,
	output logic            out_valid,
	input  logic            out_ready,
	output sfk_pkg::pose_t  out_pose,
	output logic            out_last
);
	import sfk_pkg::*;

	localparam int AW = $clog2(MaxJoints);
	localparam int CW = $clog2(MaxJoints + 1);

	typedef enum logic [2:0] {IDLE, READ, MAT, ROT, SUM, DONE} st_t;
	st_t st_q;

	joint_t j_q;
	logic [CW-1:0] cnt_q;
	logic child_q;
	logic signed [31:0] lo_q, hi_q;
	logic [2:0] step_q;

	logic [AW-1:0] waddr, raddr;
	logic we;
	logic [31:0] px_r, py_r, pz_r;
	logic [63:0] rot_r;
	logic signed [31:0] wx, wy, wz;
	logic signed [15:0] wq [4];
	logic signed [15:0] x, y, z, w;
	logic signed [29:0] m_q [9];
	logic signed [35:0] q_acc [4];
	logic signed [64:0] acc_q [3];

	assign waddr = cnt_q[AW-1:0];
	assign raddr = AW'(j_q.parent[7:0]);
	assign we = (st_q == SUM) && (cnt_q < CW'(MaxJoints));
	assign x = rot_r[15:0];
	assign y = rot_r[31:16];
	assign z = rot_r[47:32];
	assign w = rot_r[63:48];

	sfk_ram #(.Width(32), .Depth(MaxJoints)) u_px (.clk, .we, .waddr, .wdata(wx),
		.raddr, .rdata(px_r));
	sfk_ram #(.Width(32), .Depth(MaxJoints)) u_py (.clk, .we, .waddr, .wdata(wy),
		.raddr, .rdata(py_r));
	sfk_ram #(.Width(32), .Depth(MaxJoints)) u_pz (.clk, .we, .waddr, .wdata(wz),
		.raddr, .rdata(pz_r));
	sfk_ram #(.Width(64), .Depth(MaxJoints)) u_rot (.clk, .we, .waddr,
		.wdata({wq[3], wq[2], wq[1], wq[0]}), .raddr, .rdata(rot_r));

	assign q_ready = (st_q == IDLE) && !out_valid;

	// rotated offset rounding and parent position add
	function automatic logic signed [31:0] place(input logic signed [64:0] a,
			input logic signed [31:0] p);
		logic signed [64:0] r;
		r = (a + 65'sd8388608) >>> 24;
		return sat32(48'(r) + 48'(p));
	endfunction

	function automatic logic signed [29:0] rnd4(input logic signed [33:0] v);
		logic signed [33:0] s;
		s = (v + 34'sd8) >>> 4;
		return s[29:0];
	endfunction

	always_comb begin
		if (child_q) begin
			wx = place(acc_q[0], px_r);
			wy = place(acc_q[1], py_r);
			wz = place(acc_q[2], pz_r);
			for (int i = 0; i < 4; i++) wq[i] = sat16((q_acc[i] + 36'sd8192) >>> 14);
		end else begin
			wx = j_q.x;
			wy = j_q.y;
			wz = j_q.z;
			wq[0] = j_q.qx;
			wq[1] = j_q.qy;
			wq[2] = j_q.qz;
			wq[3] = j_q.qw;
		end
	end

	logic signed [31:0] sq [6];
	always_comb begin
		sq[0] = y * y; sq[1] = z * z; sq[2] = x * x;
		sq[3] = x * y; sq[4] = z * w; sq[5] = x * z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= IDLE;
			cnt_q     <= '0;
			lo_q      <= PosMax;
			hi_q      <= PosMin;
			out_valid <= 1'b0;
			step_q    <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				IDLE: if (q_valid && q_ready) begin
					st_q <= READ;
				end
				READ: st_q <= child_q ? MAT : SUM;
				MAT: st_q <= ROT;
				ROT: begin
					if (step_q == 3'd2) begin
						step_q <= '0;
						st_q <= SUM;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				SUM: st_q <= DONE;
				DONE: begin
					out_valid <= 1'b1;
					st_q <= IDLE;
					if (j_q.last) begin
						cnt_q <= '0;
						lo_q <= PosMax;
						hi_q <= PosMin;
					end else begin
						if (cnt_q < CW'(MaxJoints)) cnt_q <= cnt_q + CW'(1);
					end
				end
				default: st_q <= IDLE;
			endcase
			if (st_q == SUM) begin
				lo_q <= (wy < lo_q) ? wy : lo_q;
				hi_q <= (wy > hi_q) ? wy : hi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == IDLE && q_valid && q_ready) begin
			j_q <= q_joint;
			child_q <= !q_joint.parent[8] && (CW'(q_joint.parent[7:0]) < cnt_q)
				&& (MaxJoints > 256 || q_joint.parent[7:0] < 9'(MaxJoints));
		end
		if (st_q == MAT) begin
			m_q[0] <= rnd4(34'sd268435456 - 34'(2 * (34'(sq[0]) + 34'(sq[1]))));
			m_q[1] <= rnd4(34'(2 * (34'(sq[3]) - 34'(sq[4]))));
			m_q[2] <= rnd4(34'(2 * (34'(sq[5]) + 34'(y * w))));
			m_q[3] <= rnd4(34'(2 * (34'(sq[3]) + 34'(sq[4]))));
			m_q[4] <= rnd4(34'sd268435456 - 34'(2 * (34'(sq[2]) + 34'(sq[1]))));
			m_q[5] <= rnd4(34'(2 * (34'(y * z) - 34'(x * w))));
			m_q[6] <= rnd4(34'(2 * (34'(sq[5]) - 34'(y * w))));
			m_q[7] <= rnd4(34'(2 * (34'(y * z) + 34'(x * w))));
			m_q[8] <= rnd4(34'sd268435456 - 34'(2 * (34'(sq[2]) + 34'(sq[0]))));
			q_acc[0] <= 36'(w * j_q.qx) + 36'(x * j_q.qw) + 36'(y * j_q.qz) - 36'(z * j_q.qy);
			q_acc[1] <= 36'(w * j_q.qy) - 36'(x * j_q.qz) + 36'(y * j_q.qw) + 36'(z * j_q.qx);
			q_acc[2] <= 36'(w * j_q.qz) + 36'(x * j_q.qy) - 36'(y * j_q.qx) + 36'(z * j_q.qw);
			q_acc[3] <= 36'(w * j_q.qw) - 36'(x * j_q.qx) - 36'(y * j_q.qy) - 36'(z * j_q.qz);
			for (int r = 0; r < 3; r++) acc_q[r] <= '0;
		end
		if (st_q == ROT) begin
			// one offset column per step
			for (int r = 0; r < 3; r++) begin
				unique case (step_q)
					3'd0: acc_q[r] <= acc_q[r] + 65'(m_q[r * 3] * j_q.x);
					3'd1: acc_q[r] <= acc_q[r] + 65'(m_q[r * 3 + 1] * j_q.y);
					default: acc_q[r] <= acc_q[r] + 65'(m_q[r * 3 + 2] * j_q.z);
				endcase
			end
		end
		if (st_q == SUM) begin
			out_pose.x  <= wx;
			out_pose.y  <= wy;
			out_pose.z  <= wz;
			out_pose.qx <= wq[0];
			out_pose.qy <= wq[1];
			out_pose.qz <= wq[2];
			out_pose.qw <= wq[3];
			out_pose.lo <= (wy < lo_q) ? wy : lo_q;
			out_pose.hi <= (wy > hi_q) ? wy : hi_q;
			out_last    <= j_q.last;
		end
	end
endmodule

>>> rtl/core/skeleton_forward_kinematics_top.sv
// Top level of the skeleton forward kinematics block.
// channel | dir | tdata                                   | tuser
// s_axis  | in  | parent,x,y,z,qx,qy,qz,qw (176 bits)      | -     tlast=final_joint
// m_axis  | out | x,y,z,qx,qy,qz,qw,min,max (224 bits)     | -     tlast=skeleton_done
// A joint leaving the queue passes a registered pose-table read; a child then adds
// a matrix build and three multiply-accumulate steps before the output register.
// A two-entry queue takes joints while the engine works; the engine starts the
// next joint once its result register is free.
// Reset is asynchronous; pose tables are not cleared.
module skeleton_forward_kinematics_top #(
	parameter int MAX_JOINTS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [175:0] s_axis_tdata,  // parent, x, y, z, qx, qy, qz, qw
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [223:0] m_axis_tdata,  // x, y, z, qx, qy, qz, qw, min, max
	output logic         m_axis_tlast
);
	import sfk_pkg::*;

	joint_t in_joint, q_joint;
	pose_t pose;
	logic q_valid, q_ready;

	assign in_joint = {s_axis_tlast, s_axis_tdata[168:0]};
	assign m_axis_tdata = pose;

	sfk_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_joint, .q_valid, .q_ready, .q_joint);

	sfk_back #(.MaxJoints(MAX_JOINTS)) u_back (.clk, .arst_n, .q_valid, .q_ready,
		.q_joint, .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_pose(pose), .out_last(m_axis_tlast));
endmodule

>>> rtl/core/sfk_checker.sv
// Port-level checker for the skeleton forward kinematics block, with its bind.
`include "skeleton_forward_kinematics_top_assert.svh"
module sfk_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [223:0] m_axis_tdata,
	input logic         m_axis_tlast
);
	`SFK_ASSERT_IMPL(a_order, clk, arst_n, m_axis_tvalid, $signed(m_axis_tdata[191:160]) <= $signed(m_axis_tdata[223:192]))
	`SFK_ASSERT_IMPL(a_minle, clk, arst_n, m_axis_tvalid, $signed(m_axis_tdata[191:160]) <= $signed(m_axis_tdata[63:32]))
	`SFK_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	`SFK_ASSERT_NEXT(a_gap, clk, arst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind skeleton_forward_kinematics_top sfk_checker u_sfk_checker (.*);

>>> verif/tb_top.sv
// Testbench for the skeleton forward kinematics block: directed table, then random skeletons.
module tb_top;
	import sfk_pkg::*;

	typedef struct {
		pose_t pose;
		logic  done;
	} world_pose_t;

	typedef struct {
		joint_t      joint;
		bit          typed;
		world_pose_t want;
	} joint_row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata = '0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [223:0] m_axis_tdata;
	logic         m_axis_tlast;

	skeleton_forward_kinematics_top u_dut (.*);

	always #5 clk = ~clk;

	world_pose_t pending_poses[$];
	int          mismatches = 0;
	bit          hold_req = 0;
	bit          quiet = 0;

	// predictor state
	int                 fk_count = 0;
	logic signed [31:0] fk_px[256];
	logic signed [31:0] fk_py[256];
	logic signed [31:0] fk_pz[256];
	logic signed [15:0] fk_rot[256][4];
	logic signed [31:0] fk_low = PosMax;
	logic signed [31:0] fk_high = PosMin;

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return PosMax;
		if (v < -64'sd2147483648) return PosMin;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic world_pose_t place_joint(joint_t j);
		world_pose_t r;
		longint      t[3];
		longint      lq[4];
		longint      m[3][3];
		longint      x, y, z, w, acc, one;
		longint      pp[3];
		int          p;
		one = 64'sd1 << 28;
		t[0] = j.x; t[1] = j.y; t[2] = j.z;
		lq[0] = j.qx; lq[1] = j.qy; lq[2] = j.qz; lq[3] = j.qw;
		p = j.parent;
		if (p < 0 || p >= fk_count) begin
			r.pose.x = j.x; r.pose.y = j.y; r.pose.z = j.z;
			r.pose.qx = j.qx; r.pose.qy = j.qy; r.pose.qz = j.qz; r.pose.qw = j.qw;
		end else begin
			x = fk_rot[p][0]; y = fk_rot[p][1]; z = fk_rot[p][2]; w = fk_rot[p][3];
			m[0][0] = one - 2 * (y * y + z * z);
			m[0][1] = 2 * (x * y - z * w);
			m[0][2] = 2 * (x * z + y * w);
			m[1][0] = 2 * (x * y + z * w);
			m[1][1] = one - 2 * (x * x + z * z);
			m[1][2] = 2 * (y * z - x * w);
			m[2][0] = 2 * (x * z - y * w);
			m[2][1] = 2 * (y * z + x * w);
			m[2][2] = one - 2 * (x * x + y * y);
			pp[0] = fk_px[p]; pp[1] = fk_py[p]; pp[2] = fk_pz[p];
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += rnd_shift(m[i][k], 4) * t[k];
				pp[i] = clamp32(pp[i] + rnd_shift(acc, 24));
			end
			r.pose.x = 32'(pp[0]); r.pose.y = 32'(pp[1]); r.pose.z = 32'(pp[2]);
			r.pose.qx = clamp16(rnd_shift(w * lq[0] + x * lq[3] + y * lq[2] - z * lq[1], 14));
			r.pose.qy = clamp16(rnd_shift(w * lq[1] - x * lq[2] + y * lq[3] + z * lq[0], 14));
			r.pose.qz = clamp16(rnd_shift(w * lq[2] + x * lq[1] - y * lq[0] + z * lq[3], 14));
			r.pose.qw = clamp16(rnd_shift(w * lq[3] - x * lq[0] - y * lq[1] - z * lq[2], 14));
		end
		if (fk_count < 256) begin
			fk_px[fk_count] = r.pose.x;
			fk_py[fk_count] = r.pose.y;
			fk_pz[fk_count] = r.pose.z;
			fk_rot[fk_count][0] = r.pose.qx;
			fk_rot[fk_count][1] = r.pose.qy;
			fk_rot[fk_count][2] = r.pose.qz;
			fk_rot[fk_count][3] = r.pose.qw;
			fk_count++;
		end
		if (r.pose.y < fk_low) fk_low = r.pose.y;
		if (r.pose.y > fk_high) fk_high = r.pose.y;
		r.pose.lo = fk_low;
		r.pose.hi = fk_high;
		r.done = j.last;
		if (j.last) begin
			fk_count = 0;
			fk_low = PosMax;
			fk_high = PosMin;
		end
		return r;
	endfunction

	task automatic send_joint(joint_t j, bit typed, world_pose_t want);
		world_pose_t got;
		int          gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		repeat (gap) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, j.qw, j.qz, j.qy, j.qx, j.z, j.y, j.x, j.parent};
		s_axis_tlast <= j.last;
		do @(posedge clk); while (!s_axis_tready);
		got = place_joint(j);
		pending_poses = {pending_poses, (typed ? want : got)};
	endtask

	task automatic send_next(joint_t j);
		world_pose_t none;
		none = '{default: '0};
		send_joint(j, 0, none);
	endtask

	function automatic joint_t rand_joint(int count, bit last);
		joint_t j;
		int     sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) j.parent = $urandom;
		else if (sel == 1 || count == 0) j.parent = -1;
		else j.parent = $urandom_range(0, count - 1);
		if ($urandom_range(0, 3) == 0) begin
			j.x = $urandom; j.y = $urandom; j.z = $urandom;
		end else begin
			j.x = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			j.y = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			j.z = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		end
		if ($urandom_range(0, 3) == 0) begin
			j.qx = $urandom; j.qy = $urandom; j.qz = $urandom; j.qw = $urandom;
		end else begin
			j.qx = $signed($urandom_range(0, 16383)) - 16'sd8192;
			j.qy = $signed($urandom_range(0, 16383)) - 16'sd8192;
			j.qz = $signed($urandom_range(0, 16383)) - 16'sd8192;
			j.qw = 16'sd8192 + $signed($urandom_range(0, 8191));
		end
		j.last = last;
		return j;
	endfunction

	function automatic joint_t mk(int par, int x, int y, int z, int qx, int qy, int qz,
		int qw, bit last);
		joint_t j;
		j.parent = par; j.x = x; j.y = y; j.z = z;
		j.qx = qx; j.qy = qy; j.qz = qz; j.qw = qw; j.last = last;
		return j;
	endfunction

	function automatic world_pose_t root_pose(joint_t j, int lo, int hi);
		world_pose_t r;
		r.pose.x = j.x; r.pose.y = j.y; r.pose.z = j.z;
		r.pose.qx = j.qx; r.pose.qy = j.qy; r.pose.qz = j.qz; r.pose.qw = j.qw;
		r.pose.lo = lo; r.pose.hi = hi;
		r.done = j.last;
		return r;
	endfunction

	joint_row_t joint_table[$];

	initial begin
		joint_row_t row;
		int         len;
		row.typed = 0;
		row.want = '{default: '0};
		// roots with extreme offsets and stray parents, and children of them
		row.joint = mk(-1, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 16384, 0);
		row.typed = 1; row.want = root_pose(row.joint, PosMin, PosMin);
		joint_table = {joint_table, row};
		row.joint = mk(5, 32'h80000000, 32'h7fffffff, -1, -32768, 32767, -32768, 32767, 0);
		row.want = root_pose(row.joint, PosMin, PosMax); joint_table = {joint_table, row};
		row.typed = 0;
		row.joint = mk(0, 65536, 65536, 65536, 0, 0, 0, 16384, 0);
		joint_table = {joint_table, row};
		row.joint = mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 16384, 0);
		joint_table = {joint_table, row};
		row.joint = mk(1, 32'h80000000, 32'h80000000, 32'h80000000, -32768, -32768, -32768,
			-32768, 0);
		joint_table = {joint_table, row};
		row.joint = mk(4, 12345, -6789, 424242, 11585, 0, 0, 11585, 0);
		joint_table = {joint_table, row};
		row.joint = mk(5, -65536, 131072, 7, 0, 11585, 0, 11585, 0);
		joint_table = {joint_table, row};
		row.joint = mk(6, 1, -1, 1, 32767, 32767, 32767, 32767, 0);
		joint_table = {joint_table, row};
		row.joint = mk(255, 5, 6, 7, 1, 2, 3, 4, 0); joint_table = {joint_table, row};
		row.joint = mk(-256, 0, 0, 0, 0, 0, 0, 0, 0); joint_table = {joint_table, row};
		row.joint = mk(2, 100000, 200000, 300000, 0, 0, 16384, 0, 1);
		joint_table = {joint_table, row};
		// fresh skeleton after the final joint
		row.joint = mk(-1, 0, 32'h00010000, 0, 0, 0, 0, 16384, 0);
		row.typed = 1; row.want = root_pose(row.joint, 32'h00010000, 32'h00010000);
		joint_table = {joint_table, row};
		row.typed = 0;
		row.joint = mk(0, 0, 32'h00010000, 0, 0, 0, 0, 16384, 0);
		joint_table = {joint_table, row};
		row.joint = mk(1, 65536, 0, 0, 16384, 0, 0, 0, 0); joint_table = {joint_table, row};
		row.joint = mk(0, 0, -32768, 0, -16384, 0, 0, 0, 1); joint_table = {joint_table, row};
		// single-joint skeleton
		row.joint = mk(0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32767, -32768, 0, 0, 1);
		row.typed = 1; row.want = root_pose(row.joint, PosMax, PosMax);
		joint_table = {joint_table, row};

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (joint_table[i])
			send_joint(joint_table[i].joint, joint_table[i].typed, joint_table[i].want);

		// hold the output while the input keeps offering
		hold_req = 1;
		quiet = 1;
		for (int i = 0; i < 30; i++)
			send_next(rand_joint(fk_count, i == 29));
		quiet = 0;

		// pause until drained
		s_axis_tvalid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);

		// one oversized skeleton overflows the pose table
		for (int i = 0; i < 300; i++)
			send_next(rand_joint(fk_count, i == 299));

		for (int n = 0; n < 1450; n += len) begin
			len = $urandom_range(1, 20);
			if ($urandom_range(0, 7) == 0) quiet = ~quiet;
			for (int i = 0; i < len; i++)
				send_next(rand_joint(fk_count, i == len - 1 || $urandom_range(0, 40) == 0));
		end
		s_axis_tvalid <= 0;

		while (pending_poses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
			end
			gap = quiet ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		world_pose_t want;
		pose_t       got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_poses.pop_front();
				if (got !== want.pose || m_axis_tlast !== want.done) begin
					$display("%0t: expected %h last %b, actual %h last %b", $realtime,
						want.pose, want.done, got, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

>>> skeleton_forward_kinematics_top.f
+incdir+rtl/core
rtl/core/sfk_pkg.sv
rtl/core/sfk_ram.sv
rtl/core/sfk_front.sv
rtl/core/sfk_back.sv
rtl/core/skeleton_forward_kinematics_top.sv
rtl/core/sfk_checker.sv
verif/tb_top.sv
